// ===== rtl/core/cla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg: shared types and constants of the CR/LF line assembler
// Holds byte codes, count limits, the command word between the front and the
// back, and the back-end state type.
// ----------------------------------------------------------------------------
package cla_pkg;

  // Byte codes that end a line.
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Default line store depth and the widest count any legal depth needs.
  localparam int LINE_DEPTH_DEF = 64;
  localparam int CNT_MAX_W      = 6;

  // Completed line handed from the front to the back.
  typedef struct packed {
    logic                 empty;     // line held no bytes
    logic                 bank;      // store bank that holds the line
    logic [CNT_MAX_W-1:0] last_idx;  // index of the final byte
  } cmd_t;

  // Command queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Bank handed back once its line has been sent.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } bk_state_t;

endpackage

// ===== rtl/core/cla_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_line_store: two-bank line byte memory
// One write port for the front, one registered read port for the back.
// ----------------------------------------------------------------------------
module cla_line_store #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_r [2**ADDR_W];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/cla_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_front: byte classifier and line collector
// Accepts received bytes, stores ordinary ones into the current bank and
// posts a command when CR LF completes a line.
// ----------------------------------------------------------------------------
module cla_front #(
  parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEF,
  parameter int CNT_W      = $clog2(LINE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  cla_pkg::q_stat_t   q_stat,
  output logic               push,
  output cla_pkg::cmd_t      push_cmd,
  input  cla_pkg::release_t  rel,
  output logic               wr_en,
  output logic [CNT_W:0]     wr_addr,
  output logic [7:0]         wr_data
);
  import cla_pkg::*;

  logic             saw_r, saw_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             acc;
  logic [CNT_W:0]   fill_inc;
  logic [CNT_W-1:0] fill_m1;

  // Stall while the command queue is full or the bank in use is still sending.
  assign in_tready = !q_stat.full && !busy_r[bank_r];
  assign acc       = in_tvalid && in_tready;
  assign fill_inc  = {1'b0, fill_r} + 1'b1;
  assign fill_m1   = fill_r - 1'b1;

  assign wr_addr = {bank_r, fill_r};
  assign wr_data = in_tdata;

  // Classification and next state.
  always_comb begin
    saw_nxt  = saw_r;
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    busy_nxt = busy_r;
    push     = 1'b0;
    wr_en    = 1'b0;
    push_cmd.empty    = (fill_r == '0);
    push_cmd.bank     = bank_r;
    push_cmd.last_idx = CNT_MAX_W'(fill_m1);
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (acc) begin
      priority if (saw_r) begin
        // Line feed completes the line; anything else discards it.
        if (in_tdata == CHAR_LF) begin
          push = 1'b1;
          if (fill_r != '0) begin
            busy_nxt[bank_r] = 1'b1;
            bank_nxt         = !bank_r;
          end
        end
        saw_nxt  = 1'b0;
        fill_nxt = '0;
      end else if (in_tdata == CHAR_CR) begin
        saw_nxt = 1'b1;
      end else begin
        // Ordinary byte; a full store drops the line.
        wr_en = 1'b1;
        if (fill_inc == (CNT_W+1)'(LINE_DEPTH)) begin
          fill_nxt = '0;
        end else begin
          fill_nxt = fill_inc[CNT_W-1:0];
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saw_r  <= 1'b0;
      fill_r <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      saw_r  <= saw_nxt;
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== rtl/core/cla_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_cmd_fifo: two-entry command queue
// Decouples the line collector from the line sender.
// ----------------------------------------------------------------------------
module cla_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cla_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output cla_pkg::cmd_t     pop_cmd,
  output cla_pkg::q_stat_t  q_stat
);
  import cla_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = slot_r[rp_r];

  // Occupancy.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/cla_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_back: line sender
// Takes completed-line commands, reads the bytes from the store and presents
// them one word at a time on the output stream.
// ----------------------------------------------------------------------------
module cla_back #(
  parameter int CNT_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cla_pkg::q_stat_t   q_stat,
  input  cla_pkg::cmd_t      pop_cmd,
  output logic               pop,
  output logic               rd_en,
  output logic [CNT_W:0]     rd_addr,
  input  logic [7:0]         rd_data,
  output cla_pkg::release_t  rel,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);
  import cla_pkg::*;

  bk_state_t        state_r, state_nxt;
  logic             empty_r;
  logic             bank_r;
  logic [CNT_W-1:0] last_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             is_last;
  logic             sent;

  assign is_last = empty_r || (idx_r == last_r);
  assign sent    = (state_r == BK_SHOW) && out_tready;
  assign rd_addr = {bank_r, idx_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          idx_nxt   = '0;
          state_nxt = pop_cmd.empty ? BK_SHOW : BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_tready) begin
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = BK_FETCH;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    pop        = (state_r == BK_IDLE) && !q_stat.empty;
    rd_en      = (state_r == BK_FETCH);
    out_tvalid = (state_r == BK_SHOW);
    out_tdata  = empty_r ? '0 : rd_data;
    out_tlast  = is_last;
    out_tuser  = empty_r;
    rel.valid  = sent && is_last && !empty_r;
    rel.bank   = bank_r;
  end

  // Sequencer and current line registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      empty_r <= 1'b0;
      bank_r  <= 1'b0;
      last_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (pop) begin
        empty_r <= pop_cmd.empty;
        bank_r  <= pop_cmd.bank;
        last_r  <= pop_cmd.last_idx[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/crlf_line_assembler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_line_assembler_top: CR/LF terminated line receiver
// Collects received bytes into lines and streams each completed line out.
//
//   Channel  Direction  Word
//   in_      slave      tdata[7:0] = rx_byte
//   out_     master     tdata[7:0] = line_byte, tlast = last_of_line,
//                       tuser = empty_line
//
// Each line byte is sent as a store read and then an output word; an empty
// line goes straight to its output word once its command is taken.
// Reset is synchronous and active low; the store needs no clearing.
// Input stalls while the command queue is full or the bank being filled is
// still being sent; output stalls hold the current word.
// ----------------------------------------------------------------------------
module crlf_line_assembler_top #(
  parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] empty_line
);
  import cla_pkg::*;

  localparam int CNT_W  = $clog2(LINE_DEPTH);
  localparam int ADDR_W = CNT_W + 1;

  q_stat_t           q_stat;
  logic              push, pop;
  cmd_t              push_cmd, pop_cmd;
  release_t          rel;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  // Front: classify and collect.
  cla_front #(
    .LINE_DEPTH (LINE_DEPTH),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd),
    .rel       (rel),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Command queue between front and back.
  cla_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // Two-bank line store.
  cla_line_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Back: read out and send.
  cla_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // An empty-line marker is always the final word and carries zero data.
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("empty line marker malformed");

  // A command is never posted into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // The back only pops when a command is waiting.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // The collector never writes the bank that is being read out.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> wr_addr[ADDR_W-1] != rd_addr[ADDR_W-1])
    else $error("write into bank under readout");

endmodule
